@@ design/aes_be_pkg.sv @@
// Package: shared types, constants and AES round functions for the block encryptor.
package aes_be_pkg;

  localparam int unsigned KeyStoreBytes = 240;
  localparam int unsigned KeyWords      = KeyStoreBytes / 8;
  localparam int unsigned KeyIdxW       = $clog2(KeyWords);
  localparam int unsigned MinRounds     = 10;
  localparam int unsigned MaxRounds     = KeyStoreBytes / 16 - 1;
  localparam int unsigned RoundW        = 4;

  typedef enum logic {
    CMD_KEY_LOAD = 1'b0,
    CMD_ENCRYPT  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               load;       // capture plaintext
    logic               key_wr;     // write key word
    logic [KeyIdxW-1:0] rd_addr;    // key store read address
    logic               key_lat_hi; // latch read word as upper half of round key
    logic               key_lat_lo; // latch read word as lower half, then apply
    logic               first;      // initial add-key only
    logic               last;       // final round, no mix columns
  } dp_cmd_t;

  typedef logic [7:0] sbox_lut_t [256];

  localparam sbox_lut_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of the 128-bit state sits at bits 127-8n .. 120-8n (row-major)
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r*4+c) -: 8] = SBOX[s[127-8*(r*4+((c+r)%4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-8*c -: 8];
      a1 = s[127-8*(4+c) -: 8];
      a2 = s[127-8*(8+c) -: 8];
      a3 = s[127-8*(12+c) -: 8];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[127-8*c -: 8]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[127-8*(4+c) -: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[127-8*(8+c) -: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[127-8*(12+c) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    mix_columns = t;
  endfunction

endpackage

@@ design/aes_block_encrypt.sv @@
// Top level: AES block encryptor with a pre-expanded key store.
// Beats with tuser=0 write one 64-bit round-key word (index tdata[4:0], word
// tdata[68:5]); tuser=1 encrypts the block in tdata[196:69]. The next input
// beat is taken only after the result beat has been taken, as one shared
// round unit serves one block at a time and the key store is read twice per
// round. The user must write the round count via cfg_we_i only while idle;
// the block itself does not enforce this.
module aes_block_encrypt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [199:0]  s_axis_tdata,  // key_index, key_word, block_hi, block_lo
  input  logic          s_axis_tuser,  // cmd
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata   // cipher_hi, cipher_lo
);

  aes_be_pkg::dp_cmd_t cmd;
  logic [127:0]        st;

  aes_be_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_taken_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  aes_be_dp u_dp (
    .clk_i,
    .cmd_i     (cmd),
    .wr_idx_i  (s_axis_tdata[4:0]),
    .wr_word_i (s_axis_tdata[68:5]),
    .block_i   ({s_axis_tdata[132:69], s_axis_tdata[196:133]}),
    .state_o   (st)
  );

  assign m_axis_tdata = {st[63:0], st[127:64]};

endmodule

@@ design/aes_be_ctrl.sv @@
// Controller: sequences key reads and rounds for one block at a time.
module aes_be_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aes_be_pkg::RoundW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_cmd_i,
  output logic                            in_ready_o,
  input  logic                            out_taken_i,
  output logic                            out_valid_o,
  output aes_be_pkg::dp_cmd_t             cmd_o
);

  aes_be_pkg::state_e               state_q, state_d;
  logic [aes_be_pkg::RoundW-1:0]    rounds_q;
  logic [aes_be_pkg::RoundW-1:0]    nr;
  logic [aes_be_pkg::RoundW-1:0]    rnd_q, rnd_d;
  logic [aes_be_pkg::KeyIdxW-1:0]   base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= aes_be_pkg::RoundW'(10);
      state_q  <= aes_be_pkg::ST_IDLE;
      rnd_q    <= '0;
    end else begin
      if (cfg_we_i) rounds_q <= cfg_wdata_i;
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_comb begin
    if (rounds_q < aes_be_pkg::RoundW'(aes_be_pkg::MinRounds)) begin
      nr = aes_be_pkg::RoundW'(aes_be_pkg::MinRounds);
    end else if (rounds_q > aes_be_pkg::RoundW'(aes_be_pkg::MaxRounds)) begin
      nr = aes_be_pkg::RoundW'(aes_be_pkg::MaxRounds);
    end else begin
      nr = rounds_q;
    end
  end

  assign base = {rnd_q, 1'b0};

  always_comb begin
    state_d            = state_q;
    rnd_d              = rnd_q;
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    cmd_o              = '0;
    cmd_o.rd_addr      = base;
    cmd_o.first        = (rnd_q == '0);
    cmd_o.last         = (rnd_q == nr);
    unique case (state_q)
      aes_be_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == aes_be_pkg::CMD_ENCRYPT) begin
            cmd_o.load = 1'b1;
            rnd_d      = '0;
            state_d    = aes_be_pkg::ST_RD0;
          end else begin
            cmd_o.key_wr = 1'b1;
          end
        end
      end
      aes_be_pkg::ST_RD0: begin
        cmd_o.rd_addr = base;
        state_d       = aes_be_pkg::ST_RD1;
      end
      aes_be_pkg::ST_RD1: begin
        cmd_o.rd_addr    = base + aes_be_pkg::KeyIdxW'(1);
        cmd_o.key_lat_hi = 1'b1;
        state_d          = aes_be_pkg::ST_ROUND;
      end
      aes_be_pkg::ST_ROUND: begin
        cmd_o.key_lat_lo = 1'b1;
        if (rnd_q == nr) begin
          state_d = aes_be_pkg::ST_OUT;
        end else begin
          rnd_d   = rnd_q + aes_be_pkg::RoundW'(1);
          state_d = aes_be_pkg::ST_RD0;
        end
      end
      aes_be_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) state_d = aes_be_pkg::ST_IDLE;
      end
      default: state_d = aes_be_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/aes_be_dp.sv @@
// Datapath: round-key store, state register and shared round unit.
module aes_be_dp (
  input  logic                                clk_i,
  input  aes_be_pkg::dp_cmd_t                 cmd_i,
  input  logic [aes_be_pkg::KeyIdxW-1:0]      wr_idx_i,
  input  logic [63:0]                         wr_word_i,
  input  logic [127:0]                        block_i,
  output logic [127:0]                        state_o
);

  logic [63:0]  mem [aes_be_pkg::KeyWords];
  logic [63:0]  rd_q;
  logic [63:0]  khi_q;
  logic [127:0] st_q;
  logic [127:0] rnd;
  logic [127:0] ss;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && (wr_idx_i < aes_be_pkg::KeyIdxW'(aes_be_pkg::KeyWords))) begin
      mem[wr_idx_i] <= wr_word_i;
    end
    rd_q <= mem[cmd_i.rd_addr];
  end

  always_comb begin
    ss = aes_be_pkg::sub_shift(st_q);
    if (cmd_i.first) begin
      rnd = st_q;
    end else if (cmd_i.last) begin
      rnd = ss;
    end else begin
      rnd = aes_be_pkg::mix_columns(ss);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) st_q <= block_i;
    if (cmd_i.key_lat_hi) khi_q <= rd_q;
    if (cmd_i.key_lat_lo) st_q <= rnd ^ {khi_q, rd_q};
  end

  assign state_o = st_q;

endmodule

@@ design/aes_be_chk.sv @@
// Checker: port-level assertions for the block encryptor, bound to the top level.
module aes_be_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready && !m_axis_tvalid)
    else $error("encrypt did not start");

  a_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("key load stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

endmodule

bind aes_block_encrypt aes_be_chk u_chk (.*);

@@ tb/tb.sv @@
// Testbench for aes_block_encrypt: directed and random beats checked against an AES predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd10;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  aes_block_encrypt DUT (.*);

  always #10 clk_i = ~clk_i;

  typedef struct {
    aes_be_pkg::cmd_e cmd;
    logic [4:0]  idx;
    logic [63:0] kw;
    logic [63:0] hi;
    logic [63:0] lo;
  } beat_t;

  logic [63:0]  key_mem [aes_be_pkg::KeyWords];
  logic [3:0]   rounds_reg = 4'd10;
  logic [127:0] cipher_q [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rk_byte(int n);
    return key_mem[n >> 3][63 - 8 * (n & 7) -: 8];
  endfunction

  function automatic logic [127:0] aes_cipher(logic [63:0] hi, logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [63:0] ch, cl;
    int nr;
    nr = (rounds_reg < aes_be_pkg::MinRounds) ? aes_be_pkg::MinRounds :
         (rounds_reg > aes_be_pkg::MaxRounds) ? aes_be_pkg::MaxRounds : rounds_reg;
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63 - 8 * i -: 8];
      s[8 + i] = lo[63 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk_byte(i);
    for (int r = 1; r <= nr; r++) begin
      for (int row = 0; row < 4; row++)
        for (int c = 0; c < 4; c++)
          t[row * 4 + c] = aes_be_pkg::SBOX[s[row * 4 + ((c + row) % 4)]];
      s = t;
      if (r != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[c]; a1 = s[4 + c]; a2 = s[8 + c]; a3 = s[12 + c];
          s[c]      = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
          s[4 + c]  = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
          s[8 + c]  = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
          s[12 + c] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk_byte(r * 16 + i);
    end
    for (int i = 0; i < 8; i++) begin
      ch[63 - 8 * i -: 8] = s[i];
      cl[63 - 8 * i -: 8] = s[8 + i];
    end
    return {cl, ch};
  endfunction

  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.cmd;
    s_axis_tdata  <= {3'b0, b.lo, b.hi, b.kw, b.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (b.cmd == aes_be_pkg::CMD_KEY_LOAD) begin
      if (b.idx < aes_be_pkg::KeyWords) key_mem[b.idx] = b.kw;
    end else begin
      cipher_q.push_back(aes_cipher(b.hi, b.lo));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_rounds(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rounds_reg = v;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic beat_t rnd_beat();
    beat_t b;
    b.cmd = ($urandom_range(99) < 15) ? aes_be_pkg::CMD_KEY_LOAD : aes_be_pkg::CMD_ENCRYPT;
    b.idx = 5'($urandom_range(31));
    b.kw  = rnd64();
    b.hi  = rnd64();
    b.lo  = rnd64();
    return b;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata[63:0] !== cipher_q[0][63:0] ||
            m_axis_tdata[127:64] !== cipher_q[0][127:64]) begin
          errors++;
          if (errors <= 10)
            $display("cipher mismatch: exp hi %h lo %h, got hi %h lo %h",
                     cipher_q[0][63:0], cipher_q[0][127:64],
                     m_axis_tdata[63:0], m_axis_tdata[127:64]);
        end
        void'(cipher_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  beat_t directed [11] = '{
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd0,  64'h0, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd29, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0},
    '{aes_be_pkg::CMD_ENCRYPT,  5'd0,  64'h0, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_ENCRYPT,  5'd31, 64'hffff_ffff_ffff_ffff,
      64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd30, 64'hdead_beef_0123_4567, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd31, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_ENCRYPT,  5'd0,  64'h0, 64'h0011_2233_4455_6677,
      64'h8899_aabb_ccdd_eeff},
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd0,  64'hffff_ffff_ffff_ffff, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_ENCRYPT,  5'd7,  64'h1234, 64'h8000_0000_0000_0000,
      64'h0000_0000_0000_0001},
    '{aes_be_pkg::CMD_KEY_LOAD, 5'd0,  64'h2b7e_1516_28ae_d2a6, 64'h0, 64'h0},
    '{aes_be_pkg::CMD_ENCRYPT,  5'd0,  64'h0, 64'h3243_f6a8_885a_308d,
      64'h3131_98a2_e037_0734}
  };

  initial begin
    beat_t b;
    logic [3:0] rc_set [7] = '{4'd0, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd10};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < aes_be_pkg::KeyWords; i++) begin
      b = '{aes_be_pkg::CMD_KEY_LOAD, 5'(i), rnd64(), 64'h0, 64'h0};
      send_beat(b);
    end
    foreach (directed[i]) send_beat(directed[i]);
    foreach (rc_set[i]) begin
      set_rounds(rc_set[i]);
      send_beat(directed[2]);
      send_beat(directed[3]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 36 : (ph == 1) ? 64 : 0;
      recv_idle = (ph == 0) ? 64 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < 300; n++) begin
        if (n % 60 == 0) set_rounds(4'($urandom_range(15)));
        if (n == 150) begin
          s_axis_tvalid <= 1'b0;
          while (cipher_q.size() != 0) @(posedge clk_i);
        end
        send_beat(rnd_beat());
      end
    end

    drain();
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
